>>> rtl/core/smta_pkg.sv
// Package for the sliding median threshold alert block.
// Holds the fixed field widths, the sequencer state type and the cell control struct.
// No dependencies.
package smta_pkg;

  // Fixed widths of the configuration register and result fields
  localparam int CFG_W     = 9;
  localparam int COUNT_W   = 32;
  localparam int DM_OUT_W  = 17;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_MED
  } state_t;

  // Control broadcast to every sorted cell
  typedef struct packed {
    logic upd;  // load the new cell value this cycle
    logic del;  // window is full: evict the oldest sample while inserting
  } cell_ctrl_t;

endpackage

>>> rtl/core/smta_cell.sv
// One cell of the sorted sample row: holds one sorted value.
// Evicts and inserts in one step using values from its two neighbors.
// Depends on smta_pkg for the control struct.
module smta_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 9,
  parameter int IDX         = 0
) (
  input  logic                    clk,
  input  smta_pkg::cell_ctrl_t    ctrl_i,
  input  logic [SAMPLE_BITS-1:0]  old_i,     // sample leaving the window
  input  logic [SAMPLE_BITS-1:0]  smp_i,     // sample entering the window
  input  logic [CNT_W-1:0]        keep_i,    // entries left after eviction
  input  logic [SAMPLE_BITS-1:0]  prev_d_i,  // left neighbor after eviction
  input  logic                    prev_gt_i, // left neighbor lies above the new sample
  input  logic [SAMPLE_BITS-1:0]  next_c_i,  // right neighbor value
  output logic [SAMPLE_BITS-1:0]  c_o,
  output logic [SAMPLE_BITS-1:0]  d_o,
  output logic                    gt_o
);

  logic [SAMPLE_BITS-1:0] c_r;
  logic [SAMPLE_BITS-1:0] c_nxt;
  logic [SAMPLE_BITS-1:0] d;
  logic                   gt;

  // Close the gap left by the evicted value: pull from the right
  assign d = (ctrl_i.del && (c_r >= old_i)) ? next_c_i : c_r;

  // Cells past the kept entries count as above any sample
  assign gt = (CNT_W'(IDX) >= keep_i) || (d > smp_i);

  // Open a slot for the new sample: take from the left, or take the sample
  always_comb begin
    if (gt) begin
      c_nxt = prev_gt_i ? prev_d_i : smp_i;
    end else begin
      c_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.upd) begin
      c_r <= c_nxt;
    end
  end

  assign c_o  = c_r;
  assign d_o  = d;
  assign gt_o = gt;

endmodule

>>> rtl/core/sliding_median_threshold_alert.sv
// Sliding median threshold alert: ring of recent samples plus a row of sorted cells.
// The request and its evicted ring sample are captured at acceptance; the cell row
// update and the result register load follow together, held while the result side stalls.
// A new request is taken only while idle or during the capture of the two middle
// cells into the median registers, never during the cell row update.
// Reset: synchronous, active low; clears counters and handshake state. Stores are not cleared.
// Depends on smta_pkg and smta_cell.
module sliding_median_threshold_alert #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [smta_pkg::CFG_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          in_last_item,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_notice,
  output logic [smta_pkg::COUNT_W-1:0]  out_notice_total,
  output logic [smta_pkg::DM_OUT_W-1:0] out_doubled_median,
  output logic                          out_window_full,
  output logic                          out_final_res
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DM_W  = SAMPLE_BITS + 1;

  // ---------------------------------------------------------------------------
  // Configuration
  logic [smta_pkg::CFG_W-1:0] win_cfg_r;
  logic [CNT_W-1:0]           w_eff;
  logic [IDX_W-1:0]           mid_lo;
  logic [IDX_W-1:0]           mid_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= smta_pkg::CFG_W'(5);
    end else if (cfg_wr_en) begin
      win_cfg_r <= cfg_wr_data;
    end
  end

  // Clamp the window to one..MAX_WINDOW
  always_comb begin
    if (win_cfg_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(win_cfg_r) > MAX_WINDOW) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(win_cfg_r);
    end
  end

  // Middle positions; equal for an odd window
  assign mid_lo = IDX_W'((w_eff - CNT_W'(1)) >> 1);
  assign mid_hi = IDX_W'(w_eff >> 1);

  // ---------------------------------------------------------------------------
  // Sequencer
  smta_pkg::state_t state_r, state_nxt;
  logic in_acc;
  logic upd_fire;
  logic out_valid_r;

  assign in_acc   = in_valid && !in_stall;
  assign upd_fire = (state_r == smta_pkg::ST_UPD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smta_pkg::ST_IDLE: if (in_acc) state_nxt = smta_pkg::ST_UPD;
      smta_pkg::ST_UPD:  if (upd_fire) state_nxt = smta_pkg::ST_MED;
      smta_pkg::ST_MED: begin
        state_nxt = in_acc ? smta_pkg::ST_UPD : smta_pkg::ST_IDLE;
      end
      default:           state_nxt = smta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      smta_pkg::ST_IDLE: in_stall = 1'b0;
      smta_pkg::ST_MED:  in_stall = 1'b0;
      smta_pkg::ST_UPD:  in_stall = 1'b1;
      default:           in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smta_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture and arrival-order ring
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] smp_r;
  logic                   last_r;
  logic [SAMPLE_BITS-1:0] old_r;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       ptr_inc;
  logic                   full;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r  <= in_sample;
      last_r <= in_last_item;
      old_r  <= ring_mem[ptr_r];
    end
    if (upd_fire) begin
      ring_mem[ptr_r] <= smp_r;
    end
  end

  assign full    = (fill_r >= w_eff);
  assign ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);

  // Advance the ring slot and fill level; drop both at end of stream
  always_comb begin
    if (last_r) begin
      ptr_nxt  = '0;
      fill_nxt = '0;
    end else begin
      ptr_nxt  = (ptr_inc == w_eff) ? '0 : IDX_W'(ptr_inc);
      fill_nxt = full ? w_eff : fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cfg_wr_en) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (upd_fire) begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sorted cell row
  smta_pkg::cell_ctrl_t   cell_ctrl;
  logic [CNT_W-1:0]       keep;
  logic [SAMPLE_BITS-1:0] cell_c  [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_d  [MAX_WINDOW];
  logic                   cell_gt [MAX_WINDOW];

  assign cell_ctrl.upd = upd_fire;
  assign cell_ctrl.del = full;
  assign keep          = full ? (w_eff - CNT_W'(1)) : fill_r;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev_d;
    logic                   prev_gt;
    logic [SAMPLE_BITS-1:0] next_c;

    if (g == 0) begin : g_head
      assign prev_d  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_link
      assign prev_d  = cell_d[g-1];
      assign prev_gt = cell_gt[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_next
      assign next_c = cell_c[g+1];
    end

    smta_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W      (CNT_W),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .ctrl_i   (cell_ctrl),
      .old_i    (old_r),
      .smp_i    (smp_r),
      .keep_i   (keep),
      .prev_d_i (prev_d),
      .prev_gt_i(prev_gt),
      .next_c_i (next_c),
      .c_o      (cell_c[g]),
      .d_o      (cell_d[g]),
      .gt_o     (cell_gt[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Median capture from the two middle cells after each update
  logic [SAMPLE_BITS-1:0] med_lo_r, med_lo_nxt;
  logic [SAMPLE_BITS-1:0] med_hi_r, med_hi_nxt;

  always_comb begin
    med_lo_nxt = '0;
    med_hi_nxt = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (IDX_W'(i) == mid_lo) med_lo_nxt = med_lo_nxt | cell_c[i];
      if (IDX_W'(i) == mid_hi) med_hi_nxt = med_hi_nxt | cell_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == smta_pkg::ST_MED) begin
      med_lo_r <= med_lo_nxt;
      med_hi_r <= med_hi_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Threshold compare and notice count
  logic [DM_W-1:0]              dm;
  logic                         notice;
  logic [smta_pkg::COUNT_W-1:0] total_r, total_nxt, total_upd;

  assign dm     = full ? ({1'b0, med_lo_r} + {1'b0, med_hi_r}) : '0;
  assign notice = full && ({1'b0, smp_r} >= dm);

  // Saturate the count; the stored total is cleared at end of stream
  always_comb begin
    total_upd = total_r;
    if (notice && (total_r != '1)) begin
      total_upd = total_r + smta_pkg::COUNT_W'(1);
    end
    total_nxt = last_r ? '0 : total_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (upd_fire) begin
      total_r <= total_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_notice         <= notice;
      out_notice_total   <= total_upd;
      out_doubled_median <= smta_pkg::DM_OUT_W'(dm);
      out_window_full    <= full;
      out_final_res      <= last_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill level above window size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(ptr_r) < w_eff)
    else $error("ring slot outside window");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == smta_pkg::ST_UPD))
    else $error("result appeared without an update step");

  a_notice_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_notice) |-> out_window_full)
    else $error("notice raised before window was full");
`endif

endmodule

>>> tb/sliding_median_threshold_alert_test.sv
// Testbench for the sliding median threshold alert block.
// Drives samples and window settings, predicts every result in a scoreboard class and checks it.
// Depends on smta_pkg and the sliding_median_threshold_alert RTL.
module sliding_median_threshold_alert_test;

  localparam int SAMPLE_W    = 16;
  localparam int RING_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 300000;

  // One result as seen on the output ports
  typedef struct packed {
    logic                          notice;
    logic [smta_pkg::COUNT_W-1:0]  count;
    logic [smta_pkg::DM_OUT_W-1:0] dmed;
    logic                          full;
    logic                          fin;
  } alert_result_t;

  // Predicts the alert results and holds those still owed by the block
  class median_alert_scoreboard;
    logic [SAMPLE_W-1:0]          ring [RING_DEPTH];
    logic [SAMPLE_W-1:0]          sorted [RING_DEPTH];
    int unsigned                  fill;
    int unsigned                  ptr;
    logic [smta_pkg::CFG_W-1:0]   wsize;
    logic [smta_pkg::COUNT_W-1:0] total;
    alert_result_t                pending [$];
    int unsigned                  errors;
    int unsigned                  requests;
    int unsigned                  full_seen;
    int unsigned                  notices_seen;
    int unsigned                  ends_seen;

    function new();
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i]   = '0;
        sorted[i] = '0;
      end
      fill  = 0;
      ptr   = 0;
      wsize = smta_pkg::CFG_W'(5);
      total = '0;
    endfunction

    // A window write empties the window but keeps the notice total
    function void set_window(logic [smta_pkg::CFG_W-1:0] v);
      wsize = v;
      fill  = 0;
      ptr   = 0;
    endfunction

    // Place v into the ascending first cnt entries
    function void sorted_insert(int unsigned cnt, logic [SAMPLE_W-1:0] v);
      int unsigned pos;
      pos = cnt;
      while (pos > 0 && sorted[pos-1] > v) begin
        sorted[pos] = sorted[pos-1];
        pos--;
      end
      sorted[pos] = v;
    endfunction

    function void note_request(logic [SAMPLE_W-1:0] s, logic l);
      int unsigned   w;
      int unsigned   p;
      int unsigned   slot;
      alert_result_t exp;
      exp = '0;
      w = (wsize == 0) ? 1 : ((wsize > RING_DEPTH) ? RING_DEPTH : int'(wsize));
      p = ptr % w;
      exp.full = (fill >= w);
      if (exp.full) begin
        // Doubled median of the preceding window
        if (w % 2 == 1) exp.dmed = {sorted[(w-1)/2], 1'b0};
        else exp.dmed = {1'b0, sorted[w/2-1]} + {1'b0, sorted[w/2]};
        if ({1'b0, s} >= exp.dmed) begin
          exp.notice = 1'b1;
          if (total != {smta_pkg::COUNT_W{1'b1}}) total++;
        end
        // Evict the oldest sample, then insert the new one
        slot = w - 1;
        for (int unsigned i = 0; i < w; i++) begin
          if (sorted[i] == ring[p]) begin
            slot = i;
            break;
          end
        end
        for (int unsigned i = slot; i + 1 < w; i++) sorted[i] = sorted[i+1];
        sorted_insert(w - 1, s);
        ring[p] = s;
        fill    = w;
        full_seen++;
      end else begin
        ring[p] = s;
        sorted_insert(fill, s);
        fill++;
      end
      ptr       = (p + 1) % w;
      exp.count = total;
      exp.fin   = l;
      if (exp.notice) notices_seen++;
      if (l) begin
        fill  = 0;
        ptr   = 0;
        total = '0;
        ends_seen++;
      end
      requests++;
      pending = {pending, exp};
    endfunction

    function void check_result(alert_result_t got);
      alert_result_t exp;
      if (pending.size() == 0) begin
        $error("result arrived with no request pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.notice !== exp.notice) begin
        $error("notice: expected %0d, got %0d", exp.notice, got.notice);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("notice_total: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
      if (got.dmed !== exp.dmed) begin
        $error("doubled_median: expected %0d, got %0d", exp.dmed, got.dmed);
        errors++;
      end
      if (got.full !== exp.full) begin
        $error("window_full: expected %0d, got %0d", exp.full, got.full);
        errors++;
      end
      if (got.fin !== exp.fin) begin
        $error("final_res: expected %0d, got %0d", exp.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [smta_pkg::CFG_W-1:0]    cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [SAMPLE_W-1:0]           in_sample;
  logic                          in_last_item;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_notice;
  logic [smta_pkg::COUNT_W-1:0]  out_notice_total;
  logic [smta_pkg::DM_OUT_W-1:0] out_doubled_median;
  logic                          out_window_full;
  logic                          out_final_res;

  median_alert_scoreboard sb = new();
  alert_result_t          seen;
  int unsigned            stall_left;
  int unsigned            cycles;
  int unsigned            cfg_writes;
  bit                     tx_quiet;
  bit                     rx_quiet;

  // Window settings of the random phases and their request counts
  int unsigned win_list [11] = '{0, 2, 3, 4, 7, 8, 16, 1, 33, 256, 511};
  int unsigned cnt_list [11] = '{26, 26, 26, 26, 26, 26, 26, 26, 26, 26, 270};

  sliding_median_threshold_alert dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_notice         (out_notice),
    .out_notice_total   (out_notice_total),
    .out_doubled_median (out_doubled_median),
    .out_window_full    (out_window_full),
    .out_final_res      (out_final_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("cycle limit reached with %0d results outstanding", sb.pending.size());
      $display("FAIL");
      $finish;
    end
  end

  // Check accepted results, then choose the next stall
  always @(posedge clk) begin
    int unsigned r;
    if (rst_n && out_valid && !out_stall) begin
      seen.notice = out_notice;
      seen.count  = out_notice_total;
      seen.dmed   = out_doubled_median;
      seen.full   = out_window_full;
      seen.fin    = out_final_res;
      sb.check_result(seen);
    end
    r = $urandom_range(0, 99);
    if (rx_quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (r < 50) begin
      out_stall <= 1'b0;
    end else if (r < 96) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(9, 39);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Mostly small values so the median stays low, with spikes, ties and extremes
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return '1;
        2: return SAMPLE_W'(1);
        3: return SAMPLE_W'(16'hFFFE);
        4: return SAMPLE_W'(16'h8000);
        default: return SAMPLE_W'(16'h7FFF);
      endcase
    end
    if (r < 60) return SAMPLE_W'($urandom_range(0, 300));
    if (r < 75) return SAMPLE_W'($urandom_range(0, 3));
    return SAMPLE_W'($urandom());
  endfunction

  // Hold one request until accepted, then idle for a random gap, which may be zero
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic l);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_last_item <= l;
    forever begin
      @(posedge clk);
      if (in_stall === 1'b0) break;
    end
    sb.note_request(s, l);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write the window register once every result is back
  task automatic write_window(input logic [smta_pkg::CFG_W-1:0] v);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(v);
    cfg_writes++;
  endtask

  initial begin
    int unsigned         w;
    logic [SAMPLE_W-1:0] s;
    logic                l;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    in_sample    <= '0;
    in_last_item <= 1'b0;
    out_stall    <= 1'b0;
    stall_left   = 0;
    cycles       = 0;
    cfg_writes   = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of five: fill with extremes, spike over the median, end the stream
    push_sample(16'd0, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd1, 1'b0);
    push_sample(16'd2, 1'b0);
    push_sample(16'd3, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd4, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    // Fresh stream of all-max samples gives the largest doubled median
    repeat (5) push_sample(16'hFFFF, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd0, 1'b1);
    in_valid <= 1'b0;

    // Zero window acts as one: a zero median flags every sample
    write_window(smta_pkg::CFG_W'(0));
    push_sample(16'd0, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd1, 1'b0);
    in_valid <= 1'b0;

    // Random phases over small, even, odd and the largest windows
    for (int ph = 0; ph < 11; ph++) begin
      if (ph != 0) write_window(smta_pkg::CFG_W'(win_list[ph]));
      w        = (win_list[ph] == 0) ? 1 : win_list[ph];
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < cnt_list[ph]; k++) begin
        s = pick_sample();
        if (w >= 64) l = (win_list[ph] > 256) && (k == cnt_list[ph] - 1);
        else l = ($urandom_range(0, 24) == 0);
        push_sample(s, l);
      end
      in_valid <= 1'b0;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Drain outstanding results
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0) $error("%0d expected results never arrived", sb.pending.size());
    $display("Sent %0d samples across %0d window writes; %0d with a full window.",
             sb.requests, cfg_writes, sb.full_seen);
    $display("Predicted %0d notices and %0d stream ends.", sb.notices_seen, sb.ends_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
